// ===== rtl/tpi_pkg.sv =====
`timescale 1ns / 1ps
package tpi_pkg;

  // Default widths of the position and coefficient fields
  localparam int POS_WIDTH_DEF  = 32;
  localparam int COEF_WIDTH_DEF = 18;

  // Track slopes are signed Q4.20
  localparam int SLOPE_WIDTH = 24;
  localparam int SLOPE_FRAC  = 20;

  // Configuration register index
  localparam int CFG_INDEX_WIDTH = 3;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_ROT_ROW0,
    REG_ROT_ROW1,
    REG_ROT_ROW2,
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_ORIGIN_Z
  } cfg_reg_t;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

endpackage

// ===== rtl/tpi_track_if.sv =====
`timescale 1ns / 1ps
interface tpi_track_if #(
  parameter int PW = tpi_pkg::POS_WIDTH_DEF
) ();
  logic                                   valid;
  logic                                   ready;
  logic signed [PW-1:0]                   track_x;
  logic signed [PW-1:0]                   track_y;
  logic signed [tpi_pkg::SLOPE_WIDTH-1:0] slope_x;
  logic signed [tpi_pkg::SLOPE_WIDTH-1:0] slope_y;

  modport source (output valid, output track_x, output track_y, output slope_x,
                  output slope_y, input ready);
  modport sink (input valid, input track_x, input track_y, input slope_x,
                input slope_y, output ready);
endinterface

// ===== rtl/tpi_result_if.sv =====
`timescale 1ns / 1ps
interface tpi_result_if #(
  parameter int PW = tpi_pkg::POS_WIDTH_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic signed [PW-1:0] global_x;
  logic signed [PW-1:0] global_y;
  logic signed [PW-1:0] global_z;
  logic signed [PW-1:0] local_u;
  logic signed [PW-1:0] local_v;
  logic signed [PW-1:0] local_w;
  logic                 parallel_flag;
  logic                 overflow_flag;

  modport source (output valid, output global_x, output global_y, output global_z,
                  output local_u, output local_v, output local_w,
                  output parallel_flag, output overflow_flag, input ready);
  modport sink (input valid, input global_x, input global_y, input global_z,
                input local_u, input local_v, input local_w,
                input parallel_flag, input overflow_flag, output ready);
endinterface

// ===== rtl/tpi_front.sv =====
`timescale 1ns / 1ps
module tpi_front #(
  parameter int PW = tpi_pkg::POS_WIDTH_DEF,
  parameter int CW = tpi_pkg::COEF_WIDTH_DEF,
  localparam int SW  = tpi_pkg::SLOPE_WIDTH,
  localparam int SF  = tpi_pkg::SLOPE_FRAC,
  localparam int DW  = PW + 1,
  localparam int MW  = DW + CW,
  localparam int AW  = MW + 2,
  localparam int PMW = CW + SW,
  localparam int PDW = PMW + 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [PW-1:0] track_x,
  input  logic signed [PW-1:0] track_y,
  input  logic signed [SW-1:0] slope_x,
  input  logic signed [SW-1:0] slope_y,
  input  logic signed [CW-1:0] nrm_x,
  input  logic signed [CW-1:0] nrm_y,
  input  logic signed [CW-1:0] nrm_z,
  input  logic signed [PW-1:0] org_x,
  input  logic signed [PW-1:0] org_y,
  input  logic signed [PW-1:0] org_z,
  output logic                 q_valid,
  input  logic                 q_ready,
  output logic signed [PW-1:0] q_track_x,
  output logic signed [PW-1:0] q_track_y,
  output logic signed [SW-1:0] q_slope_x,
  output logic signed [SW-1:0] q_slope_y,
  output logic signed [AW-1:0] q_num,
  output logic signed [PDW-1:0] q_den,
  output logic                 q_parallel
);

  logic en;
  logic v1, v2, v3;

  logic signed [PW-1:0]  s1_x, s1_y, s2_x, s2_y;
  logic signed [SW-1:0]  d1_x, d1_y, d2_x, d2_y;
  logic signed [DW-1:0]  e1_x, e1_y, e1_z;
  logic signed [PMW-1:0] p1_x, p1_y;
  logic signed [MW-1:0]  a2_x, a2_y, a2_z;
  logic signed [PDW-1:0] p2, p_z;

  // Stall the whole front when the last stage cannot hand off
  assign en       = !(v3 && !q_ready);
  assign in_ready = en;
  assign q_valid  = v3;

  // Normal z times the unit z slope is a plain shift
  assign p_z = {{(PDW-CW-SF){nrm_z[CW-1]}}, nrm_z, {SF{1'b0}}};

  // Advance stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Stage 1: offsets from plane origin, slope products
  // Stage 2: offset products, normal dot direction
  // Stage 3: dot products summed, parallel check
  always_ff @(posedge clk) begin
    if (en) begin
      s1_x <= track_x;
      s1_y <= track_y;
      d1_x <= slope_x;
      d1_y <= slope_y;
      e1_x <= DW'(track_x) - DW'(org_x);
      e1_y <= DW'(track_y) - DW'(org_y);
      e1_z <= -DW'(org_z);
      p1_x <= nrm_x * slope_x;
      p1_y <= nrm_y * slope_y;

      s2_x <= s1_x;
      s2_y <= s1_y;
      d2_x <= d1_x;
      d2_y <= d1_y;
      a2_x <= e1_x * nrm_x;
      a2_y <= e1_y * nrm_y;
      a2_z <= e1_z * nrm_z;
      p2   <= PDW'(p1_x) + PDW'(p1_y) + p_z;

      q_track_x  <= s2_x;
      q_track_y  <= s2_y;
      q_slope_x  <= d2_x;
      q_slope_y  <= d2_y;
      q_num      <= AW'(a2_x) + AW'(a2_y) + AW'(a2_z);
      q_den      <= p2;
      q_parallel <= (p2 == '0);
    end
  end

endmodule

// ===== rtl/tpi_fifo.sv =====
`timescale 1ns / 1ps
module tpi_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = tpi_pkg::QUEUE_DEPTH,
  localparam int PTRW = $clog2(DEPTH),
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  logic [W-1:0]    mem [DEPTH];
  logic [PTRW-1:0] wr_ptr, rd_ptr;
  logic [CNTW-1:0] count;
  logic            push, pop;

  assign wr_ready = (count != CNTW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTRW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTRW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNTW'(push) - CNTW'(pop);
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== rtl/tpi_div.sv =====
`timescale 1ns / 1ps
module tpi_div #(
  parameter int NW   = 77,
  parameter int DENW = 44
) (
  input  logic            clk,
  input  logic            en,
  input  logic [NW-1:0]   num,
  input  logic [DENW-1:0] den,
  output logic [NW:0]     quo
);

  // Per stage: partial remainder, numerator bits shifting out while
  // quotient bits shift in, and the divisor
  logic [DENW-1:0] rem  [1:NW];
  logic [NW-1:0]   work [1:NW];
  logic [DENW-1:0] dv   [1:NW];
  logic            up;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DENW-1:0] rem_in;
    logic [NW-1:0]   work_in;
    logic [DENW-1:0] dv_in;
    logic [DENW:0]   trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign work_in = num;
      assign dv_in   = den;
    end else begin : g_next
      assign rem_in  = rem[k];
      assign work_in = work[k];
      assign dv_in   = dv[k];
    end

    assign trial = {rem_in, work_in[NW-1]};
    assign ge    = (trial >= {1'b0, dv_in});

    // Retire one quotient bit
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? DENW'(trial - {1'b0, dv_in}) : DENW'(trial);
        work[k+1] <= {work_in[NW-2:0], ge};
        dv[k+1]   <= dv_in;
      end
    end
  end

  // Round to nearest, ties away from zero
  assign up = ({rem[NW], 1'b0} >= {1'b0, dv[NW]});

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= {1'b0, work[NW]} + (NW+1)'(up);
    end
  end

endmodule

// ===== rtl/tpi_back.sv =====
`timescale 1ns / 1ps
module tpi_back #(
  parameter int PW = tpi_pkg::POS_WIDTH_DEF,
  parameter int CW = tpi_pkg::COEF_WIDTH_DEF,
  localparam int SW   = tpi_pkg::SLOPE_WIDTH,
  localparam int SF   = tpi_pkg::SLOPE_FRAC,
  localparam int DW   = PW + 1,
  localparam int MW   = DW + CW,
  localparam int AW   = MW + 2,
  localparam int PDW  = CW + SW + 2,
  localparam int NW   = AW + SW,
  localparam int SATW = NW + 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  logic signed [PW-1:0]  q_track_x,
  input  logic signed [PW-1:0]  q_track_y,
  input  logic signed [SW-1:0]  q_slope_x,
  input  logic signed [SW-1:0]  q_slope_y,
  input  logic signed [AW-1:0]  q_num,
  input  logic signed [PDW-1:0] q_den,
  input  logic                  q_parallel,
  input  logic [3*CW-1:0]       rot_row0,
  input  logic [3*CW-1:0]       rot_row1,
  input  logic [3*CW-1:0]       rot_row2,
  input  logic signed [PW-1:0]  org_x,
  input  logic signed [PW-1:0]  org_y,
  input  logic signed [PW-1:0]  org_z,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [PW-1:0]  global_x,
  output logic signed [PW-1:0]  global_y,
  output logic signed [PW-1:0]  global_z,
  output logic signed [PW-1:0]  local_u,
  output logic signed [PW-1:0]  local_v,
  output logic signed [PW-1:0]  local_w,
  output logic                  parallel_flag,
  output logic                  overflow_flag
);

  localparam int L     = AW / 2;
  localparam int HW    = AW - L + SW;
  localparam int LW    = L + 1 + SW;
  localparam int LAT   = NW + 1;
  localparam int SIDEW = 2 * PW + 4;
  localparam int SH    = CW - 2;
  localparam logic signed [AW:0] RND = {{(AW+1-SH){1'b0}}, 1'b1, {(SH-1){1'b0}}};

  function automatic logic [PW:0] sat(input logic signed [SATW-1:0] v);
    logic [SATW-PW:0] hi;
    hi = v[SATW-1:PW-1];
    if ((&hi) || !(|hi)) begin
      sat = {1'b0, v[PW-1:0]};
    end else begin
      sat = {1'b1, v[SATW-1], {(PW-1){~v[SATW-1]}}};
    end
  endfunction

  logic en;

  // Matrix entries and origin as arrays
  logic signed [CW-1:0] c [3][3];
  logic signed [PW-1:0] o [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      c[0][j] = rot_row0[CW*j +: CW];
      c[1][j] = rot_row1[CW*j +: CW];
      c[2][j] = rot_row2[CW*j +: CW];
    end
    o[0] = org_x;
    o[1] = org_y;
    o[2] = org_z;
  end

  // Stage valid bits
  logic v1, v2, v3, v5, v6, v7;
  logic vd [1:LAT];

  assign en      = !out_valid || out_ready;
  assign q_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 1; k <= LAT; k++) begin
        vd[k] <= 1'b0;
      end
    end else if (en) begin
      v1 <= q_valid;
      v2 <= v1;
      v3 <= v2;
      vd[1] <= v3;
      for (int k = 2; k <= LAT; k++) begin
        vd[k] <= vd[k-1];
      end
      v5        <= vd[LAT];
      v6        <= v5;
      v7        <= v6;
      out_valid <= v7;
    end
  end

  // Stage 1: numerator partial products split over the accumulator halves
  logic signed [HW-1:0]  ph_x, ph_y;
  logic signed [LW-1:0]  pl_x, pl_y;
  logic signed [AW-1:0]  b1_num;
  logic signed [PDW-1:0] b1_den, b2_den;
  logic signed [PW-1:0]  b1_sx, b1_sy, b2_sx, b2_sy, b3_sx, b3_sy;
  logic                  b1_par, b2_par, b3_par;
  logic signed [AW-L-1:0] num_hi;
  logic signed [L:0]      num_lo;

  assign num_hi = q_num[AW-1:L];
  assign num_lo = $signed({1'b0, q_num[L-1:0]});

  // Stage 2: full numerators
  logic signed [NW-1:0] n2 [3];

  // Stage 3: magnitudes and quotient signs
  logic [NW-1:0]   nmag [3];
  logic [PDW-1:0]  pmag;
  logic [2:0]      b3_neg;

  always_ff @(posedge clk) begin
    if (en) begin
      ph_x   <= num_hi * q_slope_x;
      ph_y   <= num_hi * q_slope_y;
      pl_x   <= num_lo * q_slope_x;
      pl_y   <= num_lo * q_slope_y;
      b1_num <= q_num;
      b1_den <= q_den;
      b1_sx  <= q_track_x;
      b1_sy  <= q_track_y;
      b1_par <= q_parallel;

      n2[0]  <= (NW'(ph_x) <<< L) + NW'(pl_x);
      n2[1]  <= (NW'(ph_y) <<< L) + NW'(pl_y);
      n2[2]  <= NW'(b1_num) <<< SF;
      b2_den <= b1_den;
      b2_sx  <= b1_sx;
      b2_sy  <= b1_sy;
      b2_par <= b1_par;

      for (int i = 0; i < 3; i++) begin
        nmag[i]   <= n2[i][NW-1] ? NW'(-n2[i]) : NW'(n2[i]);
        b3_neg[i] <= n2[i][NW-1] ^ b2_den[PDW-1];
      end
      pmag   <= b2_den[PDW-1] ? PDW'(-b2_den) : PDW'(b2_den);
      b3_sx  <= b2_sx;
      b3_sy  <= b2_sy;
      b3_par <= b2_par;
    end
  end

  // Three quotient pipelines in lockstep
  logic [NW:0] quo [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    tpi_div #(
      .NW   (NW),
      .DENW (PDW)
    ) u_div (
      .clk (clk),
      .en  (en),
      .num (nmag[i]),
      .den (pmag),
      .quo (quo[i])
    );
  end

  // Carry position, signs and parallel flag alongside the dividers
  logic [SIDEW-1:0] side [1:LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      side[1] <= {b3_sx, b3_sy, b3_neg, b3_par};
      for (int k = 2; k <= LAT; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  logic signed [PW-1:0] d_sx, d_sy;
  logic [2:0]           d_neg;
  logic                 d_par;

  assign {d_sx, d_sy, d_neg, d_par} = side[LAT];

  // Stage 5: subtract the step along the track, saturate
  logic signed [PW-1:0]   s [3];
  logic signed [NW+1:0]   dq [3];
  logic signed [NW+1:0]   delta [3];
  logic [PW:0]            gsat [3];
  logic signed [PW-1:0]   g5 [3];
  logic                   ovf5, par5;

  always_comb begin
    s[0] = d_sx;
    s[1] = d_sy;
    s[2] = '0;
    for (int i = 0; i < 3; i++) begin
      dq[i]    = $signed({1'b0, quo[i]});
      delta[i] = d_neg[i] ? -dq[i] : dq[i];
      gsat[i]  = sat(SATW'(s[i]) - SATW'(delta[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        g5[i] <= gsat[i][PW-1:0];
      end
      ovf5 <= gsat[0][PW] | gsat[1][PW] | gsat[2][PW];
      par5 <= d_par;
    end
  end

  // Stage 6: local rotation products
  logic signed [DW-1:0] e [3];
  logic signed [MW-1:0] m6 [3][3];
  logic signed [PW-1:0] g6 [3];
  logic                 ovf6, par6;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e[i] = DW'(g5[i]) - DW'(o[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          m6[i][j] <= e[i] * c[i][j];
        end
        g6[i] <= g5[i];
      end
      ovf6 <= ovf5;
      par6 <= par5;
    end
  end

  // Stage 7: column sums with rounding offset
  logic signed [AW:0]   sum7 [3];
  logic signed [PW-1:0] g7 [3];
  logic                 ovf7, par7;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        sum7[j] <= (AW+1)'(m6[0][j]) + (AW+1)'(m6[1][j]) + (AW+1)'(m6[2][j]) + RND;
        g7[j]   <= g6[j];
      end
      ovf7 <= ovf6;
      par7 <= par6;
    end
  end

  // Output stage: scale down, saturate, clear on parallel track
  logic signed [AW:0] shv [3];
  logic [PW:0]        lsat [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      shv[j]  = sum7[j] >>> SH;
      lsat[j] = sat(SATW'(shv[j]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (par7) begin
        global_x      <= '0;
        global_y      <= '0;
        global_z      <= '0;
        local_u       <= '0;
        local_v       <= '0;
        local_w       <= '0;
        parallel_flag <= 1'b1;
        overflow_flag <= 1'b0;
      end else begin
        global_x      <= g7[0];
        global_y      <= g7[1];
        global_z      <= g7[2];
        local_u       <= lsat[0][PW-1:0];
        local_v       <= lsat[1][PW-1:0];
        local_w       <= lsat[2][PW-1:0];
        parallel_flag <= 1'b0;
        overflow_flag <= ovf7 | lsat[0][PW] | lsat[1][PW] | lsat[2][PW];
      end
    end
  end

endmodule

// ===== rtl/track_plane_intercept.sv =====
`timescale 1ns / 1ps
// Channel     Role     Transfer when        Payload
// track_in    sink     valid & ready        track_x, track_y, slope_x, slope_y
// result_out  source   valid & ready        global_x/y/z, local_u/v/w, flags
// cfg         write    cfg_we               cfg_index, cfg_data
//
// One track per cycle sustained while result_out is ready. A track passes the
// front, the queue and the back, which divides an NW-bit numerator, NW =
// POS_WIDTH + COEF_WIDTH + 27, in a bit-per-stage quotient pipeline.
// Reset (synchronous, rst high) empties the pipelines and the queue and loads
// the identity matrix and a zero origin.
// A stalled result holds the back end only; the front keeps taking tracks
// until the queue fills.
module track_plane_intercept #(
  parameter int POS_WIDTH  = tpi_pkg::POS_WIDTH_DEF,
  parameter int COEF_WIDTH = tpi_pkg::COEF_WIDTH_DEF,
  localparam int CFG_WIDTH = (3 * COEF_WIDTH > POS_WIDTH) ? 3 * COEF_WIDTH : POS_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tpi_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]                cfg_data,
  tpi_track_if.sink                           track_in,
  tpi_result_if.source                        result_out
);

  localparam int PW  = POS_WIDTH;
  localparam int CW  = COEF_WIDTH;
  localparam int SW  = tpi_pkg::SLOPE_WIDTH;
  localparam int AW  = PW + CW + 3;
  localparam int PDW = CW + SW + 2;
  localparam int QW  = 2 * PW + 2 * SW + AW + PDW + 1;

  localparam logic [3*CW-1:0] ROW0_RST = (3*CW)'(1) << (CW - 2);
  localparam logic [3*CW-1:0] ROW1_RST = (3*CW)'(1) << (2 * CW - 2);
  localparam logic [3*CW-1:0] ROW2_RST = (3*CW)'(1) << (3 * CW - 2);

  logic [3*CW-1:0]      rot_row0, rot_row1, rot_row2;
  logic signed [PW-1:0] origin_x, origin_y, origin_z;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_row0 <= ROW0_RST;
      rot_row1 <= ROW1_RST;
      rot_row2 <= ROW2_RST;
      origin_x <= '0;
      origin_y <= '0;
      origin_z <= '0;
    end else if (cfg_we) begin
      case (tpi_pkg::cfg_reg_t'(cfg_index))
        tpi_pkg::REG_ROT_ROW0: rot_row0 <= cfg_data[3*CW-1:0];
        tpi_pkg::REG_ROT_ROW1: rot_row1 <= cfg_data[3*CW-1:0];
        tpi_pkg::REG_ROT_ROW2: rot_row2 <= cfg_data[3*CW-1:0];
        tpi_pkg::REG_ORIGIN_X: origin_x <= cfg_data[PW-1:0];
        tpi_pkg::REG_ORIGIN_Y: origin_y <= cfg_data[PW-1:0];
        tpi_pkg::REG_ORIGIN_Z: origin_z <= cfg_data[PW-1:0];
        default: ;
      endcase
    end
  end

  // Front: offsets and dot products
  logic                  f_valid, f_ready;
  logic signed [PW-1:0]  f_sx, f_sy;
  logic signed [SW-1:0]  f_dx, f_dy;
  logic signed [AW-1:0]  f_num;
  logic signed [PDW-1:0] f_den;
  logic                  f_par;

  tpi_front #(
    .PW (PW),
    .CW (CW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (track_in.valid),
    .in_ready   (track_in.ready),
    .track_x    (track_in.track_x),
    .track_y    (track_in.track_y),
    .slope_x    (track_in.slope_x),
    .slope_y    (track_in.slope_y),
    .nrm_x      (rot_row0[2*CW +: CW]),
    .nrm_y      (rot_row1[2*CW +: CW]),
    .nrm_z      (rot_row2[2*CW +: CW]),
    .org_x      (origin_x),
    .org_y      (origin_y),
    .org_z      (origin_z),
    .q_valid    (f_valid),
    .q_ready    (f_ready),
    .q_track_x  (f_sx),
    .q_track_y  (f_sy),
    .q_slope_x  (f_dx),
    .q_slope_y  (f_dy),
    .q_num      (f_num),
    .q_den      (f_den),
    .q_parallel (f_par)
  );

  // Queue between front and back
  logic [QW-1:0]         q_wdata, q_rdata;
  logic                  b_valid, b_ready;
  logic signed [PW-1:0]  b_sx, b_sy;
  logic signed [SW-1:0]  b_dx, b_dy;
  logic signed [AW-1:0]  b_num;
  logic signed [PDW-1:0] b_den;
  logic                  b_par;

  assign q_wdata = {f_sx, f_sy, f_dx, f_dy, f_num, f_den, f_par};
  assign {b_sx, b_sy, b_dx, b_dy, b_num, b_den, b_par} = q_rdata;

  tpi_fifo #(
    .W     (QW),
    .DEPTH (tpi_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (q_wdata),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (q_rdata)
  );

  // Back: division, global and local intercept
  tpi_back #(
    .PW (PW),
    .CW (CW)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (b_valid),
    .q_ready       (b_ready),
    .q_track_x     (b_sx),
    .q_track_y     (b_sy),
    .q_slope_x     (b_dx),
    .q_slope_y     (b_dy),
    .q_num         (b_num),
    .q_den         (b_den),
    .q_parallel    (b_par),
    .rot_row0      (rot_row0),
    .rot_row1      (rot_row1),
    .rot_row2      (rot_row2),
    .org_x         (origin_x),
    .org_y         (origin_y),
    .org_z         (origin_z),
    .out_valid     (result_out.valid),
    .out_ready     (result_out.ready),
    .global_x      (result_out.global_x),
    .global_y      (result_out.global_y),
    .global_z      (result_out.global_z),
    .local_u       (result_out.local_u),
    .local_v       (result_out.local_v),
    .local_w       (result_out.local_w),
    .parallel_flag (result_out.parallel_flag),
    .overflow_flag (result_out.overflow_flag)
  );

  // A parallel track gives all zeros and no overflow
  a_parallel_zero : assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.parallel_flag |->
      result_out.global_x == '0 && result_out.global_y == '0 &&
      result_out.global_z == '0 && result_out.local_u == '0 &&
      result_out.local_v == '0 && result_out.local_w == '0 &&
      !result_out.overflow_flag)
    else $error("parallel result not cleared");

  // A write to an unknown index leaves every register alone
  a_cfg_ignore : assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index > tpi_pkg::REG_ORIGIN_Z) |=>
      $stable(rot_row0) && $stable(rot_row1) && $stable(rot_row2) &&
      $stable(origin_x) && $stable(origin_y) && $stable(origin_z))
    else $error("unknown register index changed configuration");

  // Queue full must stall the front, never drop a track
  a_queue_stall : assert property (@(posedge clk) disable iff (rst)
    f_valid && !f_ready |-> !track_in.ready)
    else $error("front accepted a track while the queue was full");

endmodule
